// ----- rtl/jacf_pkg.sv -----
package jacf_pkg;

    // command codes, last_reg keeps CMD_NONE when nothing is held
    typedef enum logic [3:0] {
        CMD_ROT_CW  = 4'd0,
        CMD_ROT_CCW = 4'd1,
        CMD_LEFT    = 4'd2,
        CMD_RIGHT   = 4'd3,
        CMD_DOWN    = 4'd4,
        CMD_DROP    = 4'd5,
        CMD_GRAVITY = 4'd6,
        CMD_NONE    = 4'd8
    } cmd_t;

    localparam int NUM_BUTTON_CMDS = 6;
    localparam int CMD_WIDTH       = 3;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 8;
    localparam int CHAT_WIDTH      = 6;
    localparam int REP_WIDTH       = 7;
    localparam int TICK_WIDTH      = 8;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_FALL_PERIOD    = 3'd0,
        REG_GLIDE_MINIMUM  = 3'd1,
        REG_REPEAT_DELAY   = 3'd2,
        REG_REPEAT_INTVL   = 3'd3,
        REG_CHATTER_ROTATE = 3'd4,
        REG_CHATTER_MOVE   = 3'd5,
        REG_CHATTER_DROP   = 3'd6
    } cfg_idx_t;

    typedef logic [CHAT_WIDTH-1:0]        chat_t;
    typedef logic [TICK_WIDTH-1:0]        tick_t;
    typedef logic signed [REP_WIDTH-1:0]  rep_t;

    typedef struct packed {
        tick_t fall_period;
        tick_t glide_minimum;
        chat_t repeat_initial_delay;
        chat_t repeat_interval;
        chat_t chatter_rotate;
        chat_t chatter_move;
        chat_t chatter_drop;
    } cfg_t;

    typedef struct packed {
        logic fire_pressed;
        logic up_pressed;
        logic left_pressed;
        logic right_pressed;
        logic down_pressed;
        logic gliding;
    } sample_t;

    localparam tick_t FALL_PERIOD_RESET    = 8'd200;
    localparam tick_t GLIDE_MINIMUM_RESET  = 8'd75;
    localparam chat_t REPEAT_DELAY_RESET   = 6'd40;
    localparam chat_t REPEAT_INTVL_RESET   = 6'd10;
    localparam chat_t CHATTER_ROTATE_RESET = 6'd12;
    localparam chat_t CHATTER_MOVE_RESET   = 6'd0;
    localparam chat_t CHATTER_DROP_RESET   = 6'd24;

    localparam rep_t  REPEAT_RESET = -$signed({1'b0, REPEAT_DELAY_RESET});
    localparam rep_t  REPEAT_MAX   = {1'b0, {(REP_WIDTH-1){1'b1}}};
    localparam tick_t TICK_MAX     = {TICK_WIDTH{1'b1}};

endpackage

// ----- rtl/jacf_if.sv -----
interface jacf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [jacf_pkg::CFG_IDX_WIDTH-1:0]  index;
    logic [jacf_pkg::CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface jacf_sample_if;
    logic valid;
    logic ready;
    logic fire_pressed;
    logic up_pressed;
    logic left_pressed;
    logic right_pressed;
    logic down_pressed;
    logic gliding;

    modport source (output valid, output fire_pressed, output up_pressed,
                    output left_pressed, output right_pressed, output down_pressed,
                    output gliding, input ready);
    modport sink   (input valid, input fire_pressed, input up_pressed,
                    input left_pressed, input right_pressed, input down_pressed,
                    input gliding, output ready);
endinterface

interface jacf_command_if;
    logic                           valid;
    logic                           ready;
    logic [jacf_pkg::CMD_WIDTH-1:0] command;

    modport source (output valid, output command, input ready);
    modport sink   (input valid, input command, output ready);
endinterface

// ----- rtl/jacf_cfg_regs.sv -----
module jacf_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    jacf_cfg_if.sink      cfg,
    output jacf_pkg::cfg_t regs
);
    import jacf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_FALL_PERIOD:    cfg_next.fall_period          = cfg.data;
                REG_GLIDE_MINIMUM:  cfg_next.glide_minimum        = cfg.data;
                REG_REPEAT_DELAY:   cfg_next.repeat_initial_delay = cfg.data[CHAT_WIDTH-1:0];
                REG_REPEAT_INTVL:   cfg_next.repeat_interval      = cfg.data[CHAT_WIDTH-1:0];
                REG_CHATTER_ROTATE: cfg_next.chatter_rotate       = cfg.data[CHAT_WIDTH-1:0];
                REG_CHATTER_MOVE:   cfg_next.chatter_move         = cfg.data[CHAT_WIDTH-1:0];
                REG_CHATTER_DROP:   cfg_next.chatter_drop         = cfg.data[CHAT_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fall_period          <= FALL_PERIOD_RESET;
            cfg_reg.glide_minimum        <= GLIDE_MINIMUM_RESET;
            cfg_reg.repeat_initial_delay <= REPEAT_DELAY_RESET;
            cfg_reg.repeat_interval      <= REPEAT_INTVL_RESET;
            cfg_reg.chatter_rotate       <= CHATTER_ROTATE_RESET;
            cfg_reg.chatter_move         <= CHATTER_MOVE_RESET;
            cfg_reg.chatter_drop         <= CHATTER_DROP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/jacf_in_stage.sv -----
module jacf_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    jacf_sample_if.sink       sample,
    output jacf_pkg::sample_t stage_data,
    output logic              stage_valid,
    input  logic              stage_take
);
    import jacf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t data_reg;
    logic    load;

    // slot frees up in the same cycle the core takes it
    assign sample.ready = !valid_reg || stage_take;
    assign load         = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (stage_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.fire_pressed  <= sample.fire_pressed;
            data_reg.up_pressed    <= sample.up_pressed;
            data_reg.left_pressed  <= sample.left_pressed;
            data_reg.right_pressed <= sample.right_pressed;
            data_reg.down_pressed  <= sample.down_pressed;
            data_reg.gliding       <= sample.gliding;
        end
    end

    assign stage_data  = data_reg;
    assign stage_valid = valid_reg;

endmodule

// ----- rtl/jacf_filter_core.sv -----
module jacf_filter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  jacf_pkg::cfg_t    regs,
    input  jacf_pkg::sample_t stage_data,
    input  logic              stage_valid,
    output logic              stage_take,
    jacf_command_if.source    result
);
    import jacf_pkg::*;

    cmd_t  last_reg;
    cmd_t  last_next;
    rep_t  rep_reg;
    rep_t  rep_next;
    tick_t tick_reg;
    tick_t tick_next;
    chat_t ign_reg  [NUM_BUTTON_CMDS];
    chat_t ign_next [NUM_BUTTON_CMDS];

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CMD_WIDTH-1:0] out_cmd_reg;

    tick_t                      period;
    logic                       gravity;
    cmd_t                       joy;
    cmd_t                       res;
    logic [NUM_BUTTON_CMDS-1:0] busy;
    logic                       arm_en;
    logic                       dec_en;
    rep_t                       rep_restart;
    rep_t                       rep_intvl;

    assign stage_take = stage_valid && (!out_valid_reg || result.ready);

    assign rep_restart = -$signed({1'b0, regs.repeat_initial_delay});
    assign rep_intvl   = $signed({1'b0, regs.repeat_interval});

    always_comb
    begin
        period  = (stage_data.gliding && (regs.fall_period < regs.glide_minimum))
                  ? regs.glide_minimum : regs.fall_period;
        gravity = (tick_reg >= period);

        if (stage_data.fire_pressed)       joy = CMD_DROP;
        else if (stage_data.up_pressed)    joy = CMD_ROT_CW;
        else if (stage_data.left_pressed)  joy = CMD_LEFT;
        else if (stage_data.right_pressed) joy = CMD_RIGHT;
        else if (stage_data.down_pressed)  joy = CMD_DOWN;
        else                               joy = CMD_NONE;

        for (int i = 0; i < NUM_BUTTON_CMDS; i++)
        begin
            busy[i] = (ign_reg[i] != '0);
        end

        last_next = last_reg;
        rep_next  = rep_reg;
        tick_next = tick_reg;
        res       = CMD_NONE;
        arm_en    = 1'b0;
        dec_en    = 1'b0;

        if (gravity)
        begin
            tick_next = '0;
            res       = CMD_GRAVITY;
        end
        else
        begin
            dec_en = 1'b1;
            if ((joy != CMD_NONE) && busy[joy[CMD_WIDTH-1:0]])
            begin
                last_next = CMD_NONE;
            end
            else if (joy inside {CMD_LEFT, CMD_RIGHT, CMD_DOWN})
            begin
                if (last_reg != joy)
                begin
                    rep_next  = rep_restart;
                    last_next = joy;
                    res       = joy;
                end
                else if (rep_reg >= rep_intvl)
                begin
                    rep_next = '0;
                    res      = joy;
                end
                else if (rep_reg != REPEAT_MAX)
                begin
                    rep_next = rep_reg + rep_t'(1);
                end
            end
            else if (joy inside {CMD_DROP, CMD_ROT_CW})
            begin
                if (last_reg != joy)
                begin
                    last_next = joy;
                    res       = joy;
                end
            end
            else
            begin
                arm_en    = (last_reg != CMD_NONE);
                last_next = CMD_NONE;
                rep_next  = rep_restart;
            end

            if ((res == CMD_DOWN) || (res == CMD_DROP))
            begin
                tick_next = '0;
            end
            else if (tick_reg != TICK_MAX)
            begin
                tick_next = tick_reg + tick_t'(1);
            end
        end
    end

    // per-counter arm then count down, arming only an idle counter
    always_comb
    begin
        chat_t base;
        for (int i = 0; i < NUM_BUTTON_CMDS; i++)
        begin
            base = ign_reg[i];
            if (arm_en && (last_reg == cmd_t'(i)) && !busy[i])
            begin
                if ((cmd_t'(i) == CMD_ROT_CW) || (cmd_t'(i) == CMD_ROT_CCW))
                    base = regs.chatter_rotate;
                else if (cmd_t'(i) == CMD_DROP)
                    base = regs.chatter_drop;
                else
                    base = regs.chatter_move;
            end
            if (dec_en && (base != '0))
                ign_next[i] = base - chat_t'(1);
            else
                ign_next[i] = base;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stage_take)
        begin
            out_valid_next = (res != CMD_NONE);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= CMD_NONE;
            rep_reg       <= REPEAT_RESET;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUTTON_CMDS; i++)
            begin
                ign_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (stage_take)
            begin
                last_reg <= last_next;
                rep_reg  <= rep_next;
                tick_reg <= tick_next;
                for (int i = 0; i < NUM_BUTTON_CMDS; i++)
                begin
                    ign_reg[i] <= ign_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            out_cmd_reg <= res[CMD_WIDTH-1:0];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.command = out_cmd_reg;

endmodule

// ----- rtl/joystick_autorepeat_chatter_filter.sv -----
// channel   modport  payload
// cfg       sink     index[2:0] register number, data[7:0] value (6-bit regs use data[5:0])
// sample    sink     fire/up/left/right/down_pressed, gliding
// result    source   command[2:0]
//
// one sample transfer per cycle sustained while the result is not stalled; a command reaches the output
// after its sample has passed the input register and then the result register around the update logic
// samples that produce no command are absorbed without an output transfer
// reset restores the register defaults and clears the filter state, no sweep needed
// a stalled result holds the result register; the input register still takes one more sample
module joystick_autorepeat_chatter_filter (
    input  logic           clk,
    input  logic           rst_n,
    jacf_cfg_if.sink       cfg,
    jacf_sample_if.sink    sample,
    jacf_command_if.source result
);
    import jacf_pkg::*;

    // live configuration; the user must write it only while the filter is idle, the block does not enforce this
    cfg_t    regs;

    // registered sample waiting for the update logic
    sample_t stage_data;
    logic    stage_valid;
    logic    stage_take;

    jacf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // input register, refills while the core consumes
    jacf_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .stage_data  (stage_data),
        .stage_valid (stage_valid),
        .stage_take  (stage_take)
    );

    // gravity check, priority encode, repeat and chatter counters, result register
    jacf_filter_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .stage_data  (stage_data),
        .stage_valid (stage_valid),
        .stage_take  (stage_take),
        .result      (result)
    );

endmodule

// ----- tb/sv/joystick_autorepeat_chatter_filter_tb.sv -----
module joystick_autorepeat_chatter_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jacf_pkg::*;

    // run shape
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 500;

    // index outside the register map, the block must drop such a write
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

    // joystick patterns, bit order fire, up, left, right, down, gliding
    localparam sample_t S_IDLE  = 6'b000000;
    localparam sample_t S_FIRE  = 6'b100000;
    localparam sample_t S_UP    = 6'b010000;
    localparam sample_t S_LEFT  = 6'b001000;
    localparam sample_t S_RIGHT = 6'b000100;
    localparam sample_t S_DOWN  = 6'b000010;
    localparam sample_t S_GLIDE = 6'b000001;

    // how the expectation of a sample is formed
    typedef enum logic [1:0] {
        EXP_PREDICT,   // from the predictor
        EXP_QUIET,     // typed in: no command
        EXP_EMIT       // typed in: the given command
    } check_kind_t;

    typedef struct {
        bit                       is_reg;
        logic [CFG_IDX_WIDTH-1:0] reg_idx;
        logic [7:0]               reg_data;
        sample_t                  smp;
        check_kind_t              check;
        cmd_t                     want;
    } step_row_t;

    logic clk;
    logic rst_n;

    jacf_cfg_if     cfg_if ();
    jacf_sample_if  smp_if ();
    jacf_command_if cmd_if ();

    joystick_autorepeat_chatter_filter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .sample (smp_if),
        .result (cmd_if)
    );

    // predictor copy of registers and filter state
    cfg_t  cfg_m;
    cmd_t  last_m;
    int    repeat_m;
    tick_t tick_m;
    chat_t ignore_m [NUM_BUTTON_CMDS];

    // commands still owed by the block, oldest first
    logic [CMD_WIDTH-1:0] cmd_expected_q [$];

    // directed plan
    step_row_t plan_q [$];

    // check kind of the sample currently on the wire
    check_kind_t wire_check;
    cmd_t        wire_want;

    // idling controls
    bit calm;
    int gap_pct;
    int stall_pct;

    // bookkeeping
    int failures;
    int samples_taken;
    int commands_seen;
    int gravity_seen;
    int reg_writes;
    int settings_used;
    int stall_cycles;

    // monitor scratch
    bit                   moved;
    bit                   fired;
    cmd_t                 fired_cmd;
    logic [CMD_WIDTH-1:0] oldest;

    always #5 clk = ~clk;

    // register write as the block sees it, 6-bit fields keep the low bits
    function automatic void apply_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [7:0] d);
        case (idx)
            REG_FALL_PERIOD:    cfg_m.fall_period          = d;
            REG_GLIDE_MINIMUM:  cfg_m.glide_minimum        = d;
            REG_REPEAT_DELAY:   cfg_m.repeat_initial_delay = d[CHAT_WIDTH-1:0];
            REG_REPEAT_INTVL:   cfg_m.repeat_interval      = d[CHAT_WIDTH-1:0];
            REG_CHATTER_ROTATE: cfg_m.chatter_rotate       = d[CHAT_WIDTH-1:0];
            REG_CHATTER_MOVE:   cfg_m.chatter_move         = d[CHAT_WIDTH-1:0];
            REG_CHATTER_DROP:   cfg_m.chatter_drop         = d[CHAT_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    // one tick of the filter: gravity, priority encode, repeat and chatter handling
    function automatic void advance_filter(input sample_t s, output bit emit, output cmd_t cmd);
        tick_t period;
        cmd_t  joy;
        emit = 1'b0;
        cmd  = CMD_NONE;

        // gliding raises a short fall period to the glide minimum
        period = (s.gliding && cfg_m.fall_period < cfg_m.glide_minimum) ?
                 cfg_m.glide_minimum : cfg_m.fall_period;
        // gravity tick: joystick not sampled, chatter counters frozen
        if (tick_m >= period) begin
            tick_m = '0;
            emit   = 1'b1;
            cmd    = CMD_GRAVITY;
            return;
        end

        if (s.fire_pressed)       joy = CMD_DROP;
        else if (s.up_pressed)    joy = CMD_ROT_CW;
        else if (s.left_pressed)  joy = CMD_LEFT;
        else if (s.right_pressed) joy = CMD_RIGHT;
        else if (s.down_pressed)  joy = CMD_DOWN;
        else                      joy = CMD_NONE;

        if (joy != CMD_NONE && ignore_m[joy] != '0) begin
            // chattering press, forget the held command but keep the repeat count
            last_m = CMD_NONE;
        end else if (joy == CMD_LEFT || joy == CMD_RIGHT || joy == CMD_DOWN) begin
            if (last_m != joy) begin
                repeat_m = -int'(cfg_m.repeat_initial_delay);
                last_m   = joy;
                emit     = 1'b1;
                cmd      = joy;
            end else if (repeat_m >= int'(cfg_m.repeat_interval)) begin
                repeat_m = 0;
                emit     = 1'b1;
                cmd      = joy;
            end else if (repeat_m < int'(REPEAT_MAX)) begin
                repeat_m++;
            end
        end else if (joy == CMD_DROP || joy == CMD_ROT_CW) begin
            if (last_m != joy) begin
                last_m = joy;
                emit   = 1'b1;
                cmd    = joy;
            end
        end else begin
            // release: arm the chatter counter of what was held, only from zero
            if (last_m != CMD_NONE && ignore_m[last_m] == '0) begin
                case (last_m)
                    CMD_ROT_CW, CMD_ROT_CCW: ignore_m[last_m] = cfg_m.chatter_rotate;
                    CMD_DROP:                ignore_m[last_m] = cfg_m.chatter_drop;
                    default:                 ignore_m[last_m] = cfg_m.chatter_move;
                endcase
            end
            last_m   = CMD_NONE;
            repeat_m = -int'(cfg_m.repeat_initial_delay);
        end

        foreach (ignore_m[i])
            if (ignore_m[i] != '0) ignore_m[i]--;

        // down and drop restart the fall timer, everything else advances it
        if (emit && (cmd == CMD_DOWN || cmd == CMD_DROP))
            tick_m = '0;
        else if (tick_m != TICK_MAX)
            tick_m++;
    endfunction

    function automatic void plan_sample(sample_t s, check_kind_t k, cmd_t c);
        step_row_t r;
        r.is_reg   = 1'b0;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.smp      = s;
        r.check    = k;
        r.want     = c;
        plan_q.push_back(r);
    endfunction

    function automatic void plan_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [7:0] d);
        step_row_t r;
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = d;
        r.smp      = S_IDLE;
        r.check    = EXP_QUIET;
        r.want     = CMD_NONE;
        plan_q.push_back(r);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 8;
            default: return 20;
        endcase
    endfunction

    // short values mostly, full byte now and then so the masking is hit
    function automatic logic [7:0] pick_short();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 24));
    endfunction

    // one sample transfer, called at a falling edge, returns at a falling edge
    task automatic send_sample(sample_t s, check_kind_t k, cmd_t c);
        smp_if.valid = 1'b1;
        {smp_if.fire_pressed, smp_if.up_pressed, smp_if.left_pressed,
         smp_if.right_pressed, smp_if.down_pressed, smp_if.gliding} = s;
        wire_check = k;
        wire_want  = c;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        @(negedge clk);
        // sender gap burst
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            smp_if.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [7:0] d);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = d;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // wait for every owed command, then let quiet samples leave the pipeline
    task automatic settle();
        smp_if.valid = 1'b0;
        while (cmd_expected_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(logic [7:0] fall, logic [7:0] glide, logic [7:0] delay,
                                 logic [7:0] intvl, logic [7:0] rot, logic [7:0] mv,
                                 logic [7:0] drp);
        settle();
        write_register(REG_FALL_PERIOD, fall);
        write_register(REG_GLIDE_MINIMUM, glide);
        write_register(REG_REPEAT_DELAY, delay);
        write_register(REG_REPEAT_INTVL, intvl);
        write_register(REG_CHATTER_ROTATE, rot);
        write_register(REG_CHATTER_MOVE, mv);
        write_register(REG_CHATTER_DROP, drp);
        settings_used++;
    endtask

    // mostly presses held for a while then released, some raw noise in between
    task automatic run_phase(int n);
        int      sent;
        int      base;
        int      hold;
        int      lower;
        bit      glide;
        sample_t s;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 15) begin
                s = sample_t'($urandom_range(0, 63));
                send_sample(s, EXP_PREDICT, CMD_NONE);
                sent++;
            end else begin
                // base bit 5 fire .. 1 down, lower priority bits ride along at random
                base  = $urandom_range(1, 5);
                lower = (1 << base) - 2;
                hold  = (base <= 3) ? $urandom_range(1, 80) : $urandom_range(1, 20);
                glide = ($urandom_range(0, 2) == 0);
                repeat (hold) begin
                    s = sample_t'((1 << base) | ($urandom_range(0, 63) & lower));
                    s.gliding = glide ^ ($urandom_range(0, 15) == 0);
                    send_sample(s, EXP_PREDICT, CMD_NONE);
                    sent++;
                end
                // release stretch, short ones probe the chatter window
                repeat ($urandom_range(0, 25)) begin
                    s = S_IDLE;
                    s.gliding = glide;
                    send_sample(s, EXP_PREDICT, CMD_NONE);
                    sent++;
                end
            end
        end
    endtask

    // receiver stall bursts, none once the run turns calm
    always begin
        @(negedge clk);
        if (rst_n && !calm && $urandom_range(0, 99) < stall_pct) begin
            cmd_if.ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
            cmd_if.ready = 1'b1;
        end
    end

    // transfer monitor: predictor update, command check and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            moved = 1'b0;

            if (cfg_if.valid && cfg_if.ready) begin
                apply_register(cfg_if.index, cfg_if.data);
                reg_writes++;
                moved = 1'b1;
            end

            if (smp_if.valid && smp_if.ready) begin
                advance_filter({smp_if.fire_pressed, smp_if.up_pressed, smp_if.left_pressed,
                                smp_if.right_pressed, smp_if.down_pressed, smp_if.gliding},
                               fired, fired_cmd);
                case (wire_check)
                    EXP_PREDICT: if (fired) cmd_expected_q.push_back(fired_cmd[CMD_WIDTH-1:0]);
                    EXP_EMIT:    cmd_expected_q.push_back(wire_want[CMD_WIDTH-1:0]);
                    default: ;
                endcase
                samples_taken++;
                moved = 1'b1;
            end

            if (cmd_if.valid && cmd_if.ready) begin
                if (cmd_expected_q.size() == 0) begin
                    $display("%0t: command %0d arrived with nothing expected",
                             $time, cmd_if.command);
                    failures++;
                end else begin
                    oldest = cmd_expected_q.pop_front();
                    if (cmd_if.command !== oldest) begin
                        $display("%0t: command expected %0d actual %0d",
                                 $time, oldest, cmd_if.command);
                        failures++;
                    end
                end
                if ({1'b0, cmd_if.command} == CMD_GRAVITY) gravity_seen++;
                commands_seen++;
                moved = 1'b1;
            end

            // no transfer on any channel for too long means the block is stuck
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d commands outstanding",
                         $time, stall_cycles, cmd_expected_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int lvl;

        // every input known from time zero
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        smp_if.valid  = 1'b0;
        {smp_if.fire_pressed, smp_if.up_pressed, smp_if.left_pressed,
         smp_if.right_pressed, smp_if.down_pressed, smp_if.gliding} = S_IDLE;
        cmd_if.ready  = 1'b1;
        wire_check    = EXP_PREDICT;
        wire_want     = CMD_NONE;
        calm          = 1'b0;
        gap_pct       = 10;
        stall_pct     = 5;
        failures      = 0;
        samples_taken = 0;
        commands_seen = 0;
        gravity_seen  = 0;
        reg_writes    = 0;
        settings_used = 1;
        stall_cycles  = 0;

        // predictor starts from the reset register values and an empty filter
        cfg_m.fall_period          = FALL_PERIOD_RESET;
        cfg_m.glide_minimum        = GLIDE_MINIMUM_RESET;
        cfg_m.repeat_initial_delay = REPEAT_DELAY_RESET;
        cfg_m.repeat_interval      = REPEAT_INTVL_RESET;
        cfg_m.chatter_rotate       = CHATTER_ROTATE_RESET;
        cfg_m.chatter_move         = CHATTER_MOVE_RESET;
        cfg_m.chatter_drop         = CHATTER_DROP_RESET;
        last_m   = CMD_NONE;
        repeat_m = -int'(REPEAT_DELAY_RESET);
        tick_m   = '0;
        foreach (ignore_m[i]) ignore_m[i] = '0;

        // directed plan, reset registers first
        plan_sample(S_IDLE,  EXP_QUIET, CMD_NONE);     // nothing held
        plan_sample(S_FIRE,  EXP_EMIT,  CMD_DROP);     // fresh drop
        plan_sample(S_FIRE,  EXP_QUIET, CMD_NONE);     // held drop stays quiet
        plan_sample(S_IDLE,  EXP_QUIET, CMD_NONE);     // release arms drop chatter
        plan_sample(S_FIRE,  EXP_QUIET, CMD_NONE);     // drop inside chatter window
        plan_sample(S_UP,    EXP_EMIT,  CMD_ROT_CW);   // rotate, ccw never appears
        plan_sample(S_UP,    EXP_QUIET, CMD_NONE);     // held rotate stays quiet
        plan_sample(S_IDLE,  EXP_QUIET, CMD_NONE);     // release arms rotate chatter
        plan_sample(S_UP,    EXP_QUIET, CMD_NONE);     // rotate inside chatter window
        plan_sample(S_LEFT,  EXP_EMIT,  CMD_LEFT);
        plan_sample(S_LEFT,  EXP_QUIET, CMD_NONE);     // still in initial delay
        plan_sample(S_RIGHT, EXP_EMIT,  CMD_RIGHT);    // direct switch
        plan_sample(S_DOWN,  EXP_EMIT,  CMD_DOWN);
        plan_sample(S_FIRE | S_UP | S_LEFT | S_RIGHT | S_DOWN | S_GLIDE,
                    EXP_PREDICT, CMD_NONE);            // everything at once
        // no delay, interval masked down to zero, long move chatter, stray index
        plan_write(REG_REPEAT_DELAY, 8'h00);
        plan_write(REG_REPEAT_INTVL, 8'hC0);
        plan_write(REG_CHATTER_MOVE, 8'h3F);
        plan_write(REG_UNUSED, 8'h55);
        plan_sample(S_LEFT,          EXP_EMIT,  CMD_LEFT);
        plan_sample(S_LEFT,          EXP_EMIT,  CMD_LEFT);   // repeat every tick
        plan_sample(S_LEFT | S_DOWN, EXP_EMIT,  CMD_LEFT);   // left wins over down
        plan_sample(S_IDLE,          EXP_QUIET, CMD_NONE);   // arms move chatter
        plan_sample(S_LEFT,          EXP_QUIET, CMD_NONE);   // left ignored
        plan_sample(S_RIGHT,         EXP_EMIT,  CMD_RIGHT);  // own counter is clear
        // shortest fall period against the largest glide minimum
        plan_write(REG_FALL_PERIOD, 8'd1);
        plan_write(REG_GLIDE_MINIMUM, 8'd255);
        plan_sample(S_IDLE,           EXP_PREDICT, CMD_NONE);
        plan_sample(S_IDLE,           EXP_PREDICT, CMD_NONE);
        plan_sample(S_IDLE | S_GLIDE, EXP_PREDICT, CMD_NONE);
        plan_sample(S_DOWN | S_GLIDE, EXP_PREDICT, CMD_NONE);
        plan_write(REG_FALL_PERIOD, 8'd255);
        plan_write(REG_GLIDE_MINIMUM, 8'd0);
        plan_sample(S_UP | S_GLIDE,   EXP_PREDICT, CMD_NONE);

        // single reset, released on a falling edge
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // walk the directed plan, registers only with the block drained
        foreach (plan_q[i]) begin
            if (plan_q[i].is_reg) begin
                settle();
                write_register(plan_q[i].reg_idx, plan_q[i].reg_data);
            end else begin
                send_sample(plan_q[i].smp, plan_q[i].check, plan_q[i].want);
            end
        end

        // random phases: lowest settings, highest settings, then game-like ones
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                apply_setting(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            end else if (phase == 1) begin
                apply_setting(8'd255, 8'd255, 8'd63, 8'd63, 8'd63, 8'd63, 8'd63);
            end else begin
                lvl = $urandom_range(0, 40);
                apply_setting(8'(400 / (lvl + 2)), 8'($urandom_range(0, 255)),
                              pick_short(), pick_short(), pick_short(),
                              pick_short(), pick_short());
            end
            // last phase runs with no idling on either side
            calm      = (phase == PHASES - 1);
            gap_pct   = calm ? 0 : pick_pct();
            stall_pct = calm ? 0 : pick_pct();
            run_phase(PHASE_ITEMS);
        end

        settle();
        if (cmd_expected_q.size() != 0) begin
            $display("%0t: %0d expected commands never arrived", $time, cmd_expected_q.size());
            failures++;
        end

        $display("covered %0d samples and %0d register writes over %0d settings",
                 samples_taken, reg_writes, settings_used);
        $display("checked %0d commands, %0d of them gravity, %0d failures",
                 commands_seen, gravity_seen, failures);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/jacf_pkg.sv
rtl/jacf_if.sv
rtl/jacf_cfg_regs.sv
rtl/jacf_in_stage.sv
rtl/jacf_filter_core.sv
rtl/joystick_autorepeat_chatter_filter.sv
tb/sv/joystick_autorepeat_chatter_filter_tb.sv
